FILE: rtl/tqba_pkg.sv
// Shared constants, codes and types for the two-queue bridge arbiter.
package tqba_pkg;

  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned IdBitsDef     = 8;

  localparam int unsigned LimitW = 4;
  localparam logic [LimitW-1:0] LimitReset = 4'd2;

  localparam logic CmdArrive  = 1'b0;
  localparam logic CmdRelease = 1'b1;

  typedef enum logic [1:0] {
    ERR_OK           = 2'd0,
    ERR_QUEUE_FULL   = 2'd1,
    ERR_IDLE_RELEASE = 2'd2
  } err_e;

  // Per-cycle command to one queue.
  typedef struct packed {
    logic push;
    logic pop;
    logic rd_en;
  } q_ctrl_t;

  // Occupancy flags of one queue.
  typedef struct packed {
    logic empty;
    logic full;
    logic one;
  } q_stat_t;

endpackage

FILE: rtl/tqba_queue.sv
// Requester id queue: one synchronous memory with head, tail and fill count.
module tqba_queue #(
  parameter int unsigned QueueDepth = 16,
  parameter int unsigned IdBits     = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tqba_pkg::q_ctrl_t   ctrl_i,
  input  logic [IdBits-1:0]   wdata_i,
  output tqba_pkg::q_stat_t   stat_o,
  output logic [IdBits-1:0]   rdata_o
);
  import tqba_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QueueDepth - 1);

  logic [IdBits-1:0] mem [QueueDepth];
  logic [IdBits-1:0] rdata_q;
  logic [PtrW-1:0]   head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              push_ok, pop_ok;

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CntW'(QueueDepth));
  assign stat_o.one   = (count_q == CntW'(1));

  assign push_ok = ctrl_i.push && !stat_o.full;
  assign pop_ok  = ctrl_i.pop && !stat_o.empty;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (push_ok) begin
      tail_d  = (tail_q == PtrLast) ? '0 : tail_q + PtrW'(1);
      count_d = count_q + CntW'(1);
    end else if (pop_ok) begin
      head_d  = (head_q == PtrLast) ? '0 : head_q + PtrW'(1);
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem[tail_q] <= wdata_i;
    end
    if (ctrl_i.rd_en) begin
      rdata_q <= mem[head_q];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/two_queue_bridge_arbiter.sv
// Top level: east-favoured arbiter with burst limit over two id queues.
//
//  channel  | direction | tdata (low bit up)                  | tuser
//  s_*      | in        | go_west, requester_id                | cmd
//  m_*      | out       | grant_valid, grant_id, grant_west,   | -
//           |           | error_code                           |
//  cfg_*    | in        | east_burst_limit, write on cfg_we_i  | -
//
// An item that gives no result passes accept and update only; one that flags
// an error adds the load of the output register, and a grant adds a head read
// from the queue memory before that load. One item is at work at a time.
// The output register holds a result while the next item is taken in; the
// load of a new result waits until the held one has been transferred.
// Reset clears counters, pointers, busy flag and limit (to 2); queue memories
// are not cleared.
module two_queue_bridge_arbiter #(
  parameter int unsigned QueueDepth = tqba_pkg::QueueDepthDef,
  parameter int unsigned IdBits     = tqba_pkg::IdBitsDef,
  localparam int unsigned InW  = ((1 + IdBits + 7) / 8) * 8,
  localparam int unsigned OutW = ((IdBits + 4 + 7) / 8) * 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tqba_pkg::LimitW-1:0] cfg_wdata_i,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [InW-1:0]              s_tdata,   // go_west, requester_id
  input  logic                        s_tuser,   // cmd
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [OutW-1:0]             m_tdata    // grant_valid, grant_id,
                                                 // grant_west, error_code
);
  import tqba_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_EMIT
  } state_e;

  state_e            state_q;
  logic [LimitW-1:0] limit_q;
  logic              cmd_q, west_q;
  logic [IdBits-1:0] id_q;
  logic              busy_q, holder_w_q;
  logic [LimitW-1:0] burst_q, burst_d;
  logic              gvalid_q, gwest_q;
  err_e              err_q, err_d;
  logic              m_valid_q, m_gvalid_q, m_gwest_q;
  logic [IdBits-1:0] m_gid_q;
  err_e              m_err_q;

  q_ctrl_t           e_ctrl, w_ctrl;
  q_stat_t           e_stat, w_stat;
  logic [IdBits-1:0] e_rdata, w_rdata;

  logic is_rel, push_e, push_w, drop, idle_rel, pop_e, pop_w;
  logic busy_after, e_nz, w_nz, grant_e, grant_w;
  logic out_load;

  tqba_queue #(.QueueDepth(QueueDepth), .IdBits(IdBits)) u_east_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (e_ctrl),
    .wdata_i (id_q),
    .stat_o  (e_stat),
    .rdata_o (e_rdata)
  );

  tqba_queue #(.QueueDepth(QueueDepth), .IdBits(IdBits)) u_west_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (w_ctrl),
    .wdata_i (id_q),
    .stat_o  (w_stat),
    .rdata_o (w_rdata)
  );

  // Decode of the held item against current queue and arbiter state.
  always_comb begin
    is_rel   = (cmd_q == CmdRelease);
    push_e   = !is_rel && !west_q;
    push_w   = !is_rel && west_q;
    drop     = (push_e && e_stat.full) || (push_w && w_stat.full);
    idle_rel = is_rel && !busy_q;
    pop_e    = is_rel && busy_q && !holder_w_q;
    pop_w    = is_rel && busy_q && holder_w_q;

    burst_d = burst_q;
    if (pop_w && (burst_q >= limit_q)) begin
      burst_d = '0;
    end else if (pop_e && !w_stat.empty && (burst_q < limit_q)) begin
      burst_d = burst_q + LimitW'(1);
    end

    // Occupancy after this item's push or pop.
    e_nz = (push_e && !e_stat.full) ? 1'b1
         : pop_e ? (!e_stat.empty && !e_stat.one) : !e_stat.empty;
    w_nz = (push_w && !w_stat.full) ? 1'b1
         : pop_w ? (!w_stat.empty && !w_stat.one) : !w_stat.empty;

    busy_after = busy_q && !is_rel;
    grant_e    = !busy_after && e_nz && (!w_nz || (burst_d < limit_q));
    grant_w    = !busy_after && !grant_e && w_nz;

    err_d = drop ? ERR_QUEUE_FULL : (idle_rel ? ERR_IDLE_RELEASE : ERR_OK);

    e_ctrl.push  = (state_q == ST_EXEC) && push_e;
    e_ctrl.pop   = (state_q == ST_EXEC) && pop_e;
    e_ctrl.rd_en = (state_q == ST_READ) && !gwest_q;
    w_ctrl.push  = (state_q == ST_EXEC) && push_w;
    w_ctrl.pop   = (state_q == ST_EXEC) && pop_w;
    w_ctrl.rd_en = (state_q == ST_READ) && gwest_q;

    // Load the output register when no result is held or the held one is taken.
    out_load = (state_q == ST_EMIT) && (!m_valid_q || m_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cmd_q      <= CmdArrive;
      west_q     <= 1'b0;
      id_q       <= '0;
      busy_q     <= 1'b0;
      holder_w_q <= 1'b0;
      burst_q    <= '0;
      gvalid_q   <= 1'b0;
      gwest_q    <= 1'b0;
      err_q      <= ERR_OK;
      m_valid_q  <= 1'b0;
      m_gvalid_q <= 1'b0;
      m_gwest_q  <= 1'b0;
      m_gid_q    <= '0;
      m_err_q    <= ERR_OK;
    end else begin
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_tvalid) begin
            cmd_q   <= s_tuser;
            west_q  <= s_tdata[0];
            id_q    <= s_tdata[IdBits:1];
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          burst_q  <= burst_d;
          busy_q   <= busy_after || grant_e || grant_w;
          gvalid_q <= grant_e || grant_w;
          gwest_q  <= grant_w;
          err_q    <= err_d;
          if (grant_e || grant_w) begin
            holder_w_q <= grant_w;
            state_q    <= ST_READ;
          end else if (err_d != ERR_OK) begin
            state_q <= ST_EMIT;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_READ: begin
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          // Hold until the previous result has been transferred.
          if (out_load) begin
            m_gvalid_q <= gvalid_q;
            m_gwest_q  <= gwest_q;
            m_gid_q    <= !gvalid_q ? '0 : (gwest_q ? w_rdata : e_rdata);
            m_err_q    <= err_q;
            state_q    <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_tready = (state_q == ST_IDLE);
  assign m_tvalid = m_valid_q;
  assign m_tdata  = OutW'({m_err_q, m_gwest_q, m_gid_q, m_gvalid_q});

endmodule

FILE: bench/tb_two_queue_bridge_arbiter.sv
// Self-checking stream testbench for the two-queue bridge arbiter.
`timescale 1ns / 1ps

module tb_two_queue_bridge_arbiter;
  import tqba_pkg::*;

  localparam int unsigned Depth     = QueueDepthDef;
  localparam int unsigned InW       = 16;
  localparam int unsigned OutW      = 16;
  localparam int unsigned RandItems = 1950;
  localparam int unsigned Phases    = 10;
  localparam int unsigned SettleCyc = 8;

  typedef struct {
    logic       gvalid;
    logic [7:0] gid;
    logic       gwest;
    err_e       err;
  } grant_t;

  // Mirrors the arbitration state and holds the results still owed by the block.
  class grant_scoreboard;
    logic [LimitW-1:0] burst_limit;
    logic [7:0]        east_ids[Depth];
    logic [7:0]        west_ids[Depth];
    int unsigned       east_cnt, west_cnt, east_head, west_head;
    logic [3:0]        burst_cnt;
    bit                busy, holder_west;
    grant_t            owed[$];
    int unsigned       faults;

    function new();
      burst_limit = LimitReset;
      east_cnt = 0;
      west_cnt = 0;
      east_head = 0;
      west_head = 0;
      burst_cnt = 0;
      busy = 0;
      holder_west = 0;
      faults = 0;
    endfunction

    function void note_item(logic cmd, logic west, logic [7:0] id);
      grant_t g;
      g.gvalid = 1'b0;
      g.gid = 8'd0;
      g.gwest = 1'b0;
      g.err = ERR_OK;
      if (cmd == CmdArrive) begin
        if (west) begin
          if (west_cnt >= Depth) g.err = ERR_QUEUE_FULL;
          else begin
            west_ids[(west_head + west_cnt) % Depth] = id;
            west_cnt++;
          end
        end else begin
          if (east_cnt >= Depth) g.err = ERR_QUEUE_FULL;
          else begin
            east_ids[(east_head + east_cnt) % Depth] = id;
            east_cnt++;
          end
        end
      end else if (!busy) begin
        g.err = ERR_IDLE_RELEASE;
      end else begin
        // pop the holder, then update the burst count
        if (holder_west) begin
          west_head = (west_head + 1) % Depth;
          west_cnt--;
          if (burst_cnt >= burst_limit) burst_cnt = 0;
        end else begin
          east_head = (east_head + 1) % Depth;
          east_cnt--;
          if (west_cnt != 0 && burst_cnt < burst_limit) burst_cnt++;
        end
        busy = 0;
      end
      if (!busy) begin
        if (east_cnt != 0 && (west_cnt == 0 || burst_cnt < burst_limit)) begin
          busy = 1;
          holder_west = 0;
          g.gvalid = 1'b1;
          g.gid = east_ids[east_head];
        end else if (west_cnt != 0) begin
          busy = 1;
          holder_west = 1;
          g.gvalid = 1'b1;
          g.gid = west_ids[west_head];
          g.gwest = 1'b1;
        end
      end
      if (g.gvalid || g.err != ERR_OK) owed.push_back(g);
    endfunction

    function void check_grant(logic [OutW-1:0] data);
      grant_t want;
      logic   gvalid, gwest;
      logic [7:0] gid;
      logic [1:0] err;
      gvalid = data[0];
      gid = data[8:1];
      gwest = data[9];
      err = data[11:10];
      if (owed.size() == 0) begin
        faults++;
        if (faults <= 10) $display("unexpected result: tdata=%h", data);
        return;
      end
      want = owed.pop_front();
      if (gvalid !== want.gvalid || gid !== want.gid || gwest !== want.gwest ||
          err !== want.err) begin
        faults++;
        if (faults <= 10)
          $display("mismatch: expected valid=%0d id=%h west=%0d err=%0d, got valid=%0d id=%h west=%0d err=%0d",
                   want.gvalid, want.gid, want.gwest, want.err, gvalid, gid, gwest, err);
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [LimitW-1:0] cfg_wdata_i;
  logic              s_tvalid;
  logic              s_tready;
  logic [InW-1:0]    s_tdata;   // go_west, requester_id
  logic              s_tuser;   // cmd
  logic              m_tvalid;
  logic              m_tready;
  logic [OutW-1:0]   m_tdata;   // grant_valid, grant_id, grant_west, error_code

  grant_scoreboard sb;
  bit              no_stall;

  two_queue_bridge_arbiter DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_tready) sb.note_item(s_tuser, s_tdata[0], s_tdata[8:1]);
      if (m_tvalid && m_tready) sb.check_grant(m_tdata);
    end
  end

  // Result side: random stall before each transfer.
  initial begin : sink
    int gap;
    m_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = no_stall ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        m_tready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_tready = 1'b1;
      do @(posedge clk_i); while (!m_tvalid);
      @(negedge clk_i);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(logic cmd, logic west, logic [7:0] id);
    int gap;
    gap = no_stall ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tuser = cmd;
    s_tdata = {7'd0, id, west};
    s_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
  endtask

  // Drain outstanding results, let the block go idle, then write the limit.
  task automatic set_limit(logic [LimitW-1:0] value);
    s_tvalid = 1'b0;
    while (sb.owed.size() != 0) @(negedge clk_i);
    repeat (SettleCyc) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.burst_limit = value;
  endtask

  initial begin
    logic [LimitW-1:0] limit_plan[Phases];
    int unsigned       arrive_pct, west_pct;
    limit_plan = '{4'd15, 4'd1, 4'd0, 4'd7, 4'd15, 4'd2, 4'd1, 4'd4, 4'd15, 4'd3};
    sb = new();
    no_stall = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = CmdArrive;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: idle release, fill east past full, west waiting, releases.
    send_item(CmdRelease, 1'b1, 8'hFF);
    for (int i = 0; i < 17; i++)
      send_item(CmdArrive, 1'b0, (i == 0) ? 8'hFF : (i == 1) ? 8'h00 : 8'(i * 37));
    send_item(CmdArrive, 1'b1, 8'h00);
    send_item(CmdArrive, 1'b1, 8'hFF);
    for (int i = 0; i < 4; i++) send_item(CmdRelease, i[0], 8'(i * 85));

    for (int p = 0; p < Phases; p++) begin
      set_limit(limit_plan[p]);
      no_stall = ($urandom_range(0, 3) == 0);
      arrive_pct = $urandom_range(30, 85);
      west_pct = $urandom_range(20, 80);
      for (int i = 0; i < RandItems / Phases; i++) begin
        send_item(($urandom_range(0, 99) < arrive_pct) ? CmdArrive : CmdRelease,
                  ($urandom_range(0, 99) < west_pct), 8'($urandom_range(0, 255)));
      end
    end

    s_tvalid = 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.faults == 0 && sb.owed.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
